### rtl/core/kar_pkg.sv
// kar_pkg: shared types and constants for the key auto-repeat block.
// Used by kar_core and key_auto_repeat_accel; no dependencies.
package kar_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned StepsW = 4;

  localparam logic [CfgIdxW-1:0] CFG_INITIAL_DELAY   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_INTERVAL   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_INTERVAL    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ACCEL_STEPS = 2'd3;

  localparam logic [7:0] RST_INITIAL_DELAY   = 8'd12;
  localparam logic [7:0] RST_BASE_INTERVAL   = 8'd4;
  localparam logic [7:0] RST_MIN_INTERVAL    = 8'd1;
  localparam logic [3:0] RST_MAX_ACCEL_STEPS = 4'd6;

  // hold-time thresholds
  localparam logic [7:0] HOLD_T75 = 8'd75;
  localparam logic [7:0] HOLD_T60 = 8'd60;
  localparam logic [7:0] HOLD_T45 = 8'd45;
  localparam logic [7:0] HOLD_T30 = 8'd30;
  localparam logic [7:0] HOLD_T22 = 8'd22;
  localparam logic [7:0] HOLD_T15 = 8'd15;
  localparam logic [StepsW-1:0] STEPS_T45 = 4'd4;

  localparam logic [7:0] CNT_MAX = 8'd255;

  localparam logic signed [1:0] DIR_NONE = 2'sd0;
  localparam logic signed [1:0] DIR_POS  = 2'sd1;
  localparam logic signed [1:0] DIR_NEG  = -2'sd1;

  typedef struct packed {
    logic            key_right;
    logic            key_left;
    logic            key_down;
    logic            up_held;
    logic            scrolling;
    logic            axis;
  } kar_in_t;

  typedef struct packed {
    logic signed [1:0]  direction;
    logic               triggered;
    logic [StepsW-1:0]  steps;
  } kar_res_t;

endpackage

### rtl/core/kar_core.sv
// kar_core: direction decode, hold/repeat counters and config registers.
// Produces one result per accepted word; depends on kar_pkg.
module kar_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [kar_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [kar_pkg::CfgDataW-1:0]    cfg_wdata,
  input  logic                            step,
  input  kar_pkg::kar_in_t                item,
  output kar_pkg::kar_res_t               res
);

  logic [7:0] initial_delay_r;
  logic [7:0] base_interval_r;
  logic [7:0] min_interval_r;
  logic [3:0] max_accel_steps_r;

  logic signed [1:0] last_dir_r, last_dir_nxt;
  logic [7:0] repeat_cnt_r, repeat_cnt_nxt;
  logic [7:0] hold_cnt_r, hold_cnt_nxt;
  logic       in_delay_r, in_delay_nxt;

  logic              pos, neg;
  logic signed [1:0] dir;
  logic [7:0]        hold_inc, rep_inc, interval, iv_raw, delay;
  logic [3:0]        steps_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_delay_r   <= kar_pkg::RST_INITIAL_DELAY;
      base_interval_r   <= kar_pkg::RST_BASE_INTERVAL;
      min_interval_r    <= kar_pkg::RST_MIN_INTERVAL;
      max_accel_steps_r <= kar_pkg::RST_MAX_ACCEL_STEPS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kar_pkg::CFG_INITIAL_DELAY:   initial_delay_r   <= cfg_wdata;
        kar_pkg::CFG_BASE_INTERVAL:   base_interval_r   <= cfg_wdata;
        kar_pkg::CFG_MIN_INTERVAL:    min_interval_r    <= cfg_wdata;
        kar_pkg::CFG_MAX_ACCEL_STEPS: max_accel_steps_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos = item.axis ? item.key_down : item.key_right;
    neg = item.axis ? item.up_held  : item.key_left;
    dir = pos ? kar_pkg::DIR_POS : (neg ? kar_pkg::DIR_NEG : kar_pkg::DIR_NONE);

    hold_inc = (hold_cnt_r == kar_pkg::CNT_MAX) ? hold_cnt_r : hold_cnt_r + 8'd1;
    rep_inc  = (repeat_cnt_r == kar_pkg::CNT_MAX) ? repeat_cnt_r : repeat_cnt_r + 8'd1;

    // interval and steps follow the hold count after this frame's increment
    priority if (hold_inc > kar_pkg::HOLD_T60) iv_raw = 8'd1;
    else if (hold_inc > kar_pkg::HOLD_T45)    iv_raw = 8'd2;
    else if (hold_inc > kar_pkg::HOLD_T22)    iv_raw = 8'd3;
    else                                      iv_raw = base_interval_r;
    interval = (iv_raw < min_interval_r) ? min_interval_r : iv_raw;
    delay = in_delay_r ? initial_delay_r : interval;

    priority if (hold_inc > kar_pkg::HOLD_T75) steps_hold = max_accel_steps_r;
    else if (hold_inc > kar_pkg::HOLD_T45)    steps_hold = kar_pkg::STEPS_T45;
    else if (hold_inc > kar_pkg::HOLD_T30)    steps_hold = 4'd3;
    else if (hold_inc > kar_pkg::HOLD_T15)    steps_hold = 4'd2;
    else                                      steps_hold = 4'd1;

    last_dir_nxt   = last_dir_r;
    repeat_cnt_nxt = repeat_cnt_r;
    hold_cnt_nxt   = hold_cnt_r;
    in_delay_nxt   = in_delay_r;
    res.direction  = dir;
    res.triggered  = 1'b0;
    res.steps      = 4'd1;

    if (dir != last_dir_r) begin
      last_dir_nxt   = dir;
      repeat_cnt_nxt = '0;
      hold_cnt_nxt   = '0;
      in_delay_nxt   = 1'b1;
      res.triggered  = (dir != kar_pkg::DIR_NONE);
    end else if (dir != kar_pkg::DIR_NONE) begin
      hold_cnt_nxt = hold_inc;
      if (!item.scrolling) begin
        repeat_cnt_nxt = rep_inc;
        if (rep_inc >= delay) begin
          repeat_cnt_nxt = '0;
          in_delay_nxt   = 1'b0;
          res.triggered  = 1'b1;
          res.steps      = steps_hold;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dir_r   <= kar_pkg::DIR_NONE;
      repeat_cnt_r <= '0;
      hold_cnt_r   <= '0;
      in_delay_r   <= 1'b0;
    end else if (step) begin
      last_dir_r   <= last_dir_nxt;
      repeat_cnt_r <= repeat_cnt_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      in_delay_r   <= in_delay_nxt;
    end
  end

endmodule

### rtl/core/key_auto_repeat_accel.sv
// key_auto_repeat_accel: typematic key repeat with hold-time acceleration.
// Top level; instantiates kar_core, depends on kar_pkg.
//
// Usage: send one word per frame tick on the in_ stream. in_tuser is the
// axis select (0 right/left, 1 down/up); in_tdata carries the key levels
// and the scrolling flag. Every accepted word yields exactly one result
// word on the out_ stream: direction, triggered flag and step multiplier.
// Settings are written on the cfg_ port (index 0 initial delay, 1 base
// interval, 2 min interval, 3 max accel steps) while the stream is idle.
// Each accepted result is loaded into the result register, or into the skid
// register while the receiver stalls. One word per cycle while in_tready is
// high; the counter state is updated in the same cycle the word is taken.
// A two-entry output stage (result register plus skid) keeps in_tready
// high for one more word while the receiver stalls; after that in_tready
// drops until a result is taken.
// Reset clears the counters, the held direction and the output stage and
// restores the default settings.
module key_auto_repeat_accel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // bit0 key_right, bit1 key_left, bit2 key_down, bit3 up_held,
  // bit4 scrolling, bits7:5 zero
  input  logic [7:0]                    in_tdata,
  // bit0 axis
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // bits1:0 direction (signed), bit2 triggered, bits6:3 steps, bit7 zero
  output logic [7:0]                    out_tdata,
  input  logic                          cfg_we,
  input  logic [kar_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [kar_pkg::CfgDataW-1:0]  cfg_wdata
);

  kar_pkg::kar_in_t  item;
  kar_pkg::kar_res_t res;
  kar_pkg::kar_res_t out_r, skid_r;
  logic              out_v_r, skid_v_r;
  logic              in_acc, out_load;

  assign item.key_right = in_tdata[0];
  assign item.key_left  = in_tdata[1];
  assign item.key_down  = in_tdata[2];
  assign item.up_held   = in_tdata[3];
  assign item.scrolling = in_tdata[4];
  assign item.axis      = in_tuser;

  assign in_tready = !skid_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = !out_v_r || out_tready;

  kar_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (in_acc),
    .item      (item),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (out_load) begin
        // skid is empty whenever a word is accepted
        out_v_r  <= skid_v_r || in_acc;
        skid_v_r <= 1'b0;
      end else if (in_acc) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= skid_v_r ? skid_r : res;
    end
    if (in_acc && !out_load) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_r.steps, out_r.triggered, out_r.direction};

endmodule

### test/key_auto_repeat_accel_tb.sv
// key_auto_repeat_accel_tb: self-checking bench for the key auto-repeat block.
// Directed table then randomized key holds over several settings, with idle and stall gaps
// on both streams; every result is checked against a typed row or a predictor. Needs kar_pkg.
module key_auto_repeat_accel_tb;

  // key level bits as they sit in in_tdata
  localparam logic [4:0] K_NONE   = 5'b00000;
  localparam logic [4:0] K_RIGHT  = 5'b00001;
  localparam logic [4:0] K_LEFT   = 5'b00010;
  localparam logic [4:0] K_DOWN   = 5'b00100;
  localparam logic [4:0] K_UP     = 5'b01000;
  localparam logic [4:0] K_SCROLL = 5'b10000;
  localparam logic [4:0] K_ALL    = 5'b11111;

  localparam logic AX_H = 1'b0;
  localparam logic AX_V = 1'b1;

  localparam logic signed [1:0] D_NONE = kar_pkg::DIR_NONE;
  localparam logic signed [1:0] D_POS  = kar_pkg::DIR_POS;
  localparam logic signed [1:0] D_NEG  = kar_pkg::DIR_NEG;

  localparam int NUM_ROWS = 25;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int LONG_RUN_MIN = 260;

  typedef struct packed {
    logic              axis;
    logic [4:0]        lvl;
    logic              typed;
    logic signed [1:0] dir;
    logic              trig;
    logic [3:0]        steps;
  } row_t;

  // typed rows carry the expected word; the rest go through the predictor
  row_t key_plan [NUM_ROWS] = '{
    '{AX_H, K_NONE,                  1'b1, D_NONE, 1'b0, 4'd1},
    '{AX_H, K_RIGHT,                 1'b1, D_POS,  1'b1, 4'd1},
    '{AX_H, K_RIGHT | K_LEFT,        1'b1, D_POS,  1'b0, 4'd1},
    '{AX_H, K_LEFT,                  1'b1, D_NEG,  1'b1, 4'd1},
    '{AX_H, K_LEFT | K_UP | K_DOWN,  1'b1, D_NEG,  1'b0, 4'd1},
    '{AX_H, K_NONE,                  1'b1, D_NONE, 1'b0, 4'd1},
    '{AX_H, K_NONE,                  1'b1, D_NONE, 1'b0, 4'd1},
    '{AX_V, K_DOWN,                  1'b1, D_POS,  1'b1, 4'd1},
    '{AX_V, K_DOWN | K_UP | K_RIGHT, 1'b1, D_POS,  1'b0, 4'd1},
    '{AX_V, K_UP,                    1'b1, D_NEG,  1'b1, 4'd1},
    '{AX_V, K_UP | K_SCROLL,         1'b1, D_NEG,  1'b0, 4'd1},
    '{AX_V, K_UP | K_SCROLL | K_LEFT, 1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP,                    1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP,                    1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP,                    1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP,                    1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP,                    1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP,                    1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP,                    1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP,                    1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP,                    1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP,                    1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP,                    1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_V, K_UP | K_RIGHT,          1'b0, D_NONE, 1'b0, 4'd0},
    '{AX_H, K_ALL,                   1'b1, D_POS,  1'b1, 4'd1}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  // bit0 right, bit1 left, bit2 down, bit3 up, bit4 scrolling
  logic [7:0]                   in_tdata;
  logic                         in_tuser;   // bit0 axis
  logic                         out_tvalid;
  logic                         out_tready;
  logic [7:0]                   out_tdata;  // bits1:0 direction, bit2 triggered, bits6:3 steps
  logic                         cfg_we;
  logic [kar_pkg::CfgIdxW-1:0]  cfg_index;
  logic [kar_pkg::CfgDataW-1:0] cfg_wdata;

  // predictor state and settings
  logic signed [1:0] held_dir;
  logic [7:0]        rpt_cnt;
  logic [7:0]        hold_cnt;
  logic              first_wait;
  logic [7:0]        set_delay;
  logic [7:0]        set_base;
  logic [7:0]        set_min;
  logic [3:0]        set_steps;

  kar_pkg::kar_res_t expected_words[$];
  int                errors;
  int                word_no;
  bit                no_gaps;

  key_auto_repeat_accel u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic kar_pkg::kar_res_t predict_frame(input logic axis,
                                                      input logic [4:0] lvl);
    kar_pkg::kar_res_t r;
    logic              pos;
    logic              neg;
    logic signed [1:0] d;
    logic [7:0]        limit;
    logic [7:0]        iv;
    pos = axis ? ((lvl & K_DOWN) != '0) : ((lvl & K_RIGHT) != '0);
    neg = axis ? ((lvl & K_UP) != '0) : ((lvl & K_LEFT) != '0);
    d = pos ? D_POS : (neg ? D_NEG : D_NONE);
    r.direction = d;
    r.triggered = 1'b0;
    r.steps = 4'd1;
    if (d != held_dir) begin
      held_dir = d;
      rpt_cnt = 8'd0;
      hold_cnt = 8'd0;
      first_wait = 1'b1;
      r.triggered = (d != D_NONE);
    end else if (d != D_NONE) begin
      if (hold_cnt != kar_pkg::CNT_MAX) hold_cnt = hold_cnt + 8'd1;
      if ((lvl & K_SCROLL) == '0) begin
        if (rpt_cnt != kar_pkg::CNT_MAX) rpt_cnt = rpt_cnt + 8'd1;
        if (hold_cnt > kar_pkg::HOLD_T60) iv = 8'd1;
        else if (hold_cnt > kar_pkg::HOLD_T45) iv = 8'd2;
        else if (hold_cnt > kar_pkg::HOLD_T22) iv = 8'd3;
        else iv = set_base;
        if (iv < set_min) iv = set_min;
        limit = first_wait ? set_delay : iv;
        if (rpt_cnt >= limit) begin
          rpt_cnt = 8'd0;
          first_wait = 1'b0;
          r.triggered = 1'b1;
          if (hold_cnt > kar_pkg::HOLD_T75) r.steps = set_steps;
          else if (hold_cnt > kar_pkg::HOLD_T45) r.steps = kar_pkg::STEPS_T45;
          else if (hold_cnt > kar_pkg::HOLD_T30) r.steps = 4'd3;
          else if (hold_cnt > kar_pkg::HOLD_T15) r.steps = 4'd2;
          else r.steps = 4'd1;
        end
      end
    end
    return r;
  endfunction

  // mostly short, now and then long
  function automatic int stall_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH word %0d %s: got %0d expected %0d", word_no, what, got, want);
    errors++;
  endtask

  task automatic send_frame(input logic axis, input logic [4:0] lvl, input logic typed,
                            input kar_pkg::kar_res_t typed_res);
    kar_pkg::kar_res_t res;
    int                gap;
    in_tvalid <= 1'b1;
    in_tuser <= axis;
    in_tdata <= {3'b000, lvl};
    do @(posedge clk); while (!in_tready);
    res = predict_frame(axis, lvl);
    expected_words.insert(expected_words.size(), typed ? typed_res : res);
    gap = (no_gaps || $urandom_range(0, 9) < 7) ? 0 : stall_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain, then program all four registers back to back
  task automatic write_settings(input logic [7:0] dly, input logic [7:0] base,
                                input logic [7:0] mn, input logic [3:0] stp);
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= kar_pkg::CFG_INITIAL_DELAY;
    cfg_wdata <= dly;
    @(posedge clk);
    cfg_index <= kar_pkg::CFG_BASE_INTERVAL;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= kar_pkg::CFG_MIN_INTERVAL;
    cfg_wdata <= mn;
    @(posedge clk);
    cfg_index <= kar_pkg::CFG_MAX_ACCEL_STEPS;
    cfg_wdata <= {4'd0, stp};
    @(posedge clk);
    cfg_we <= 1'b0;
    set_delay = dly;
    set_base = base;
    set_min = mn;
    set_steps = stp;
  endtask

  initial begin
    kar_pkg::kar_res_t row_res;
    kar_pkg::kar_res_t unused;
    logic              axis;
    logic [4:0]        lvl;
    int                sent;
    int                run_len;
    int                pick;
    int                scroll_pct;
    int                dsel;
    errors = 0;
    word_no = 0;
    no_gaps = 1'b0;
    unused = '0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'd0;
    in_tuser <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= kar_pkg::CFG_INITIAL_DELAY;
    cfg_wdata <= 8'd0;
    held_dir = D_NONE;
    rpt_cnt = 8'd0;
    hold_cnt = 8'd0;
    first_wait = 1'b0;
    set_delay = kar_pkg::RST_INITIAL_DELAY;
    set_base = kar_pkg::RST_BASE_INTERVAL;
    set_min = kar_pkg::RST_MIN_INTERVAL;
    set_steps = kar_pkg::RST_MAX_ACCEL_STEPS;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      row_res.direction = key_plan[i].dir;
      row_res.triggered = key_plan[i].trig;
      row_res.steps = key_plan[i].steps;
      send_frame(key_plan[i].axis, key_plan[i].lvl, key_plan[i].typed, row_res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      unique case (p)
        1: write_settings(8'd1, 8'd1, 8'd1, 4'd1);
        2: write_settings(8'd255, 8'd255, 8'd255, 4'd15);
        3: write_settings(8'd20, 8'd10, 8'd5, 4'd15);
        4: write_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                          8'($urandom_range(1, 255)), 4'($urandom_range(1, 15)));
        5: write_settings(8'($urandom_range(1, 40)), 8'($urandom_range(1, 255)),
                          8'($urandom_range(1, 4)), 4'($urandom_range(1, 15)));
        default: ;
      endcase
      no_gaps = (p == 2 || p == 5);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // noise: arbitrary key mixes
          run_len = $urandom_range(1, 4);
          if (run_len > ITEMS_PER_PHASE - sent) run_len = ITEMS_PER_PHASE - sent;
          for (int k = 0; k < run_len; k++) begin
            send_frame(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), 1'b0, unused);
          end
        end else begin
          axis = 1'($urandom_range(0, 1));
          dsel = $urandom_range(0, 9);
          run_len = ($urandom_range(0, 99) < 5) ? $urandom_range(LONG_RUN_MIN, 300)
                                                : $urandom_range(1, 90);
          // long holds stay whole so the hold counter can reach saturation
          if (run_len < LONG_RUN_MIN && run_len > ITEMS_PER_PHASE - sent)
            run_len = ITEMS_PER_PHASE - sent;
          pick = $urandom_range(0, 2);
          scroll_pct = (pick == 0) ? 0 : ((pick == 1) ? 10 : 60);
          for (int k = 0; k < run_len; k++) begin
            // off-axis keys are free; on-axis keys hold the chosen direction
            lvl = 5'($urandom_range(0, 15));
            if (axis == AX_H) lvl = lvl & (K_DOWN | K_UP);
            else lvl = lvl & (K_RIGHT | K_LEFT);
            if (dsel >= 1 && dsel <= 5) begin
              lvl = lvl | (axis ? K_DOWN : K_RIGHT);
              if ($urandom_range(0, 3) == 0) lvl = lvl | (axis ? K_UP : K_LEFT);
            end else if (dsel > 5) begin
              lvl = lvl | (axis ? K_UP : K_LEFT);
            end
            if ($urandom_range(0, 99) < scroll_pct) lvl = lvl | K_SCROLL;
            // occasional broken frame inside a short hold
            if (run_len < 100 && $urandom_range(0, 99) < 2) lvl = 5'($urandom_range(0, 31));
            send_frame(axis, lvl, 1'b0, unused);
          end
        end
        sent += run_len;
      end
    end

    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("key_auto_repeat_accel regression: pass");
    end else begin
      $display("key_auto_repeat_accel regression: fail");
    end
    $finish;
  end

  // result side backpressure
  initial begin
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if ($urandom_range(0, 3) != 0) begin
        out_tready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    kar_pkg::kar_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with none pending", int'(out_tdata), 0);
      end else begin
        want = expected_words.pop_front();
        if ($signed(out_tdata[1:0]) != want.direction)
          report_mismatch("direction", int'($signed(out_tdata[1:0])),
                          int'(want.direction));
        if (out_tdata[2] != want.triggered)
          report_mismatch("triggered", int'(out_tdata[2]), int'(want.triggered));
        if (out_tdata[6:3] != want.steps)
          report_mismatch("steps", int'(out_tdata[6:3]), int'(want.steps));
      end
      word_no++;
    end
  end

  initial begin
    #2000000;
    $display("key_auto_repeat_accel regression: fail");
    $finish;
  end

endmodule
